>>> rtl/ecstg_pkg.sv
// ============================================================================
// ecstg_pkg
// Shared types and constants for the external clock sync tick generator.
// ============================================================================
`default_nettype none

package ecstg_pkg;

    // Request codes
    localparam logic [2:0] REQ_UPDATE = 3'd0;
    localparam logic [2:0] REQ_CLOCK  = 3'd1;
    localparam logic [2:0] REQ_TEMPO  = 3'd2;
    localparam logic [2:0] REQ_START  = 3'd3;
    localparam logic [2:0] REQ_STOP   = 3'd4;

    // Register map (index = paddr[3:2])
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_EXT_SYNC = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_TPC      = 2'd2;
    localparam logic [1:0] REG_TPB      = 2'd3;

    // Reset values
    localparam logic [23:0] STEP_RESET  = 24'd48000;
    localparam logic [7:0]  TPC_RESET   = 8'd2;
    localparam logic [9:0]  TPB_RESET   = 10'd48;
    localparam logic [31:0] TEMPO_RESET = 32'd500000;
    localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;

    // Shared divider geometry
    localparam int unsigned DIV_W      = 64;
    localparam int unsigned DIV_ITER_W = 7;
    localparam logic [DIV_ITER_W-1:0] DIV_ITER_FULL  = 7'd64;
    localparam logic [DIV_ITER_W-1:0] DIV_ITER_SHORT = 7'd33;

    typedef struct packed {
        logic        ext_sync_enable;
        logic [23:0] step_per_update;
        logic [7:0]  ticks_per_clock;
        logic [9:0]  ticks_per_beat;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic wide;     // 1: 64-bit dividend, 0: 33-bit dividend
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/ecstg_if.sv
// ============================================================================
// ecstg_if
// Valid/ready channels for request items and result items.
// ============================================================================
`default_nettype none

interface ecstg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic        clock_level;
    logic [23:0] tempo_period;

    modport source (output valid, output req_type, output clock_level,
                    output tempo_period, input ready);
    modport sink   (input valid, input req_type, input clock_level,
                    input tempo_period, output ready);
endinterface

interface ecstg_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] tick_count;
    logic       running;
    logic       holding;

    modport source (output valid, output tick_count, output running,
                    output holding, input ready);
    modport sink   (input valid, input tick_count, input running,
                    input holding, output ready);
endinterface

`default_nettype wire

>>> rtl/ecstg_regs.sv
// ============================================================================
// ecstg_regs
// APB configuration registers for the tick generator.
// ============================================================================
`default_nettype none

module ecstg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ecstg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output ecstg_pkg::cfg_t                   cfg
);

    ecstg_pkg::cfg_t cfg_reg;
    logic [1:0]      idx;
    logic            wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext_sync_enable <= 1'b0;
            cfg_reg.step_per_update <= ecstg_pkg::STEP_RESET;
            cfg_reg.ticks_per_clock <= ecstg_pkg::TPC_RESET;
            cfg_reg.ticks_per_beat  <= ecstg_pkg::TPB_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ecstg_pkg::REG_EXT_SYNC: cfg_reg.ext_sync_enable <= pwdata[0];
                ecstg_pkg::REG_STEP:     cfg_reg.step_per_update <= pwdata[23:0];
                ecstg_pkg::REG_TPC:      cfg_reg.ticks_per_clock <= pwdata[7:0];
                ecstg_pkg::REG_TPB:      cfg_reg.ticks_per_beat  <= pwdata[9:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ecstg_pkg::REG_EXT_SYNC: prdata = {31'b0, cfg_reg.ext_sync_enable};
            ecstg_pkg::REG_STEP:     prdata = {8'b0, cfg_reg.step_per_update};
            ecstg_pkg::REG_TPC:      prdata = {24'b0, cfg_reg.ticks_per_clock};
            ecstg_pkg::REG_TPB:      prdata = {22'b0, cfg_reg.ticks_per_beat};
            default:                 prdata = 32'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ecstg_div.sv
// ============================================================================
// ecstg_div
// Shared restoring divider, one quotient bit per cycle.
// 33-bit dividend takes 33 steps, 64-bit dividend takes 64 steps.
// ============================================================================
`default_nettype none

module ecstg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ecstg_pkg::div_ctl_t         ctl,
    input  wire logic [ecstg_pkg::DIV_W-1:0] dividend,
    input  wire logic [31:0]                 divisor,
    output ecstg_pkg::div_stat_t             stat,
    output logic      [ecstg_pkg::DIV_W-1:0] quotient,
    output logic      [31:0]                 remainder
);

    localparam int unsigned SHORT_PAD = ecstg_pkg::DIV_W - 33;

    logic [ecstg_pkg::DIV_W-1:0]      dq_reg;
    logic [31:0]                      rem_reg;
    logic [31:0]                      dvs_reg;
    logic [ecstg_pkg::DIV_ITER_W-1:0] cnt_reg;
    logic                             done_reg;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic        qbit;
    logic [31:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dq_reg[ecstg_pkg::DIV_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        qbit     = !trial[32];
        rem_next = qbit ? trial[31:0] : shifted[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                rem_reg <= '0;
                dvs_reg <= divisor;
                if (ctl.wide)
                begin
                    dq_reg  <= dividend;
                    cnt_reg <= ecstg_pkg::DIV_ITER_FULL;
                end
                else
                begin
                    // left-align the 33-bit dividend
                    dq_reg  <= {dividend[32:0], {SHORT_PAD{1'b0}}};
                    cnt_reg <= ecstg_pkg::DIV_ITER_SHORT;
                end
            end
            else if (cnt_reg != '0)
            begin
                dq_reg   <= {dq_reg[ecstg_pkg::DIV_W-2:0], qbit};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - ecstg_pkg::DIV_ITER_W'(1);
                done_reg <= (cnt_reg == ecstg_pkg::DIV_ITER_W'(1));
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/external_clock_sync_tick_generator_unit.sv
// ============================================================================
// external_clock_sync_tick_generator_unit
// Tick generator with a fractional tempo accumulator and external clock sync.
//
// Usage:
//   req  : valid/ready request channel (timer update, clock level sample,
//          set tempo, start, stop). One result item per request item.
//   res  : valid/ready result channel (tick_count, running, holding).
//   APB  : four configuration registers at byte addresses 0, 4, 8, 12;
//          write only while the block is idle.
// Timing: one item at a time, ready only in idle.
//   timer update while running : 33 divider steps
//   clock edge that resyncs    : multiply, then 64 divider steps
//   all other items            : no divide
//   The divider is shared and yields one quotient bit per cycle.
// Reset: all state to reset values, tempo period 500000, stopped.
// Stall: the result register holds the item until res.ready; a next item
//   can be accepted meanwhile but its result waits in the sequencer.
// ============================================================================
`default_nettype none

module external_clock_sync_tick_generator_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ecstg_req_if.sink                         req,
    ecstg_res_if.source                       res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ecstg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV_DIV,
        S_RS_MUL,
        S_RS_DIV,
        S_DONE
    } state_t;

    ecstg_pkg::cfg_t      cfg;
    ecstg_pkg::div_stat_t div_st;
    ecstg_pkg::div_ctl_t  div_ctl_reg;
    logic [ecstg_pkg::DIV_W-1:0] div_q;
    logic [31:0]                 div_r;

    state_t      state_reg;
    logic        last_level_reg;
    logic        run_reg;
    logic        arming_reg;
    logic        hold_reg;
    logic [31:0] frac_reg;
    logic [31:0] tick_total_reg;
    logic [31:0] at_edge_reg;
    logic [31:0] since_reg;
    logic [31:0] period_reg;
    logic [23:0] last_tempo_reg;

    logic [ecstg_pkg::DIV_W-1:0] div_a_reg;
    logic [31:0] div_b_reg;
    logic [31:0] el_reg;
    logic [31:0] diff_reg;
    logic        dn_reg;
    logic [7:0]  n_rs_reg;
    logic [7:0]  n_reg;

    logic       res_valid_reg;
    logic [7:0] res_tick_reg;
    logic       res_run_reg;
    logic       res_hold_reg;

    ecstg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecstg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .stat      (div_st),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // ---------------- accept-cycle decode ----------------
    logic [7:0]  tpc_eff;
    logic [9:0]  tpb_eff;
    logic [31:0] per_eff;
    logic [32:0] acc_sum;
    logic [31:0] el_now;
    logic [7:0]  n_rs;
    logic [31:0] diff;
    logic        dn;
    logic        edge_hit;
    logic        accept;

    always_comb
    begin
        tpc_eff  = (cfg.ticks_per_clock == 8'd0) ? 8'd1 : cfg.ticks_per_clock;
        tpb_eff  = (cfg.ticks_per_beat == 10'd0) ? 10'd1 : cfg.ticks_per_beat;
        per_eff  = (period_reg == 32'd0) ? 32'd1 : period_reg;
        acc_sum  = {1'b0, frac_reg} + {9'b0, cfg.step_per_update};
        el_now   = tick_total_reg - at_edge_reg;
        n_rs     = (el_now < {24'b0, tpc_eff}) ? (tpc_eff - el_now[7:0]) : 8'd0;
        dn       = ({24'b0, tpc_eff} >= since_reg);
        diff     = dn ? ({24'b0, tpc_eff} - since_reg) : (since_reg - {24'b0, tpc_eff});
        edge_hit = req.clock_level && !last_level_reg && cfg.ext_sync_enable
                   && (run_reg || arming_reg);
        accept   = req.valid && (state_reg == S_IDLE);
    end

    // ---------------- advance finish ----------------
    logic [32:0] n33;
    logic [33:0] since_sum;
    logic [31:0] since_sat;
    logic [33:0] el_n;
    logic        over;
    logic [7:0]  clamp_n;
    logic [32:0] adv_n;
    logic [7:0]  adv_n_sat;

    always_comb
    begin
        n33       = div_q[32:0];
        since_sum = {2'b0, since_reg} + {1'b0, n33};
        since_sat = (since_sum[33:32] != 2'b0) ? ecstg_pkg::U32_MAX : since_sum[31:0];
        el_n      = {2'b0, el_reg} + {1'b0, n33};
        over      = (el_n >= {26'b0, tpc_eff});
        clamp_n   = (el_reg < {24'b0, tpc_eff}) ? (tpc_eff - 8'd1 - el_reg[7:0]) : 8'd0;
        adv_n     = (cfg.ext_sync_enable && over) ? {25'b0, clamp_n} : n33;
        adv_n_sat = (adv_n > 33'd255) ? 8'd255 : adv_n[7:0];
    end

    // ---------------- resync finish ----------------
    logic [ecstg_pkg::DIV_W-1:0] prod;
    logic [31:0] per_dn;
    logic [64:0] up_sum;
    logic [31:0] per_up;
    logic [31:0] per_new;
    logic [31:0] edge_total;

    always_comb
    begin
        prod       = diff_reg * period_reg;
        per_dn     = (div_q >= {32'b0, period_reg}) ? 32'd1 : (period_reg - div_q[31:0]);
        up_sum     = {33'b0, period_reg} + {1'b0, div_q};
        per_up     = (up_sum[64:32] != 33'b0) ? ecstg_pkg::U32_MAX : up_sum[31:0];
        per_new    = dn_reg ? per_dn : per_up;
        if (per_new == 32'd0)
        begin
            per_new = 32'd1;
        end
        edge_total = tick_total_reg + {24'b0, n_rs_reg};
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_level_reg <= 1'b0;
            run_reg        <= 1'b0;
            arming_reg     <= 1'b0;
            hold_reg       <= 1'b0;
            frac_reg       <= '0;
            tick_total_reg <= '0;
            at_edge_reg    <= '0;
            since_reg      <= '0;
            period_reg     <= ecstg_pkg::TEMPO_RESET;
            last_tempo_reg <= ecstg_pkg::TEMPO_RESET[23:0];
            div_ctl_reg    <= '0;
            div_a_reg      <= '0;
            div_b_reg      <= '0;
            el_reg         <= '0;
            diff_reg       <= '0;
            dn_reg         <= 1'b0;
            n_rs_reg       <= '0;
            n_reg          <= '0;
            res_valid_reg  <= 1'b0;
            res_tick_reg   <= '0;
            res_run_reg    <= 1'b0;
            res_hold_reg   <= 1'b0;
        end
        else
        begin
            div_ctl_reg.start <= 1'b0;
            if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg     <= 8'd0;
                        el_reg    <= el_now;
                        state_reg <= S_DONE;
                        unique case (req.req_type)
                            ecstg_pkg::REQ_UPDATE:
                            begin
                                if (run_reg)
                                begin
                                    div_a_reg        <= {31'b0, acc_sum};
                                    div_b_reg        <= per_eff;
                                    div_ctl_reg.start <= 1'b1;
                                    div_ctl_reg.wide  <= 1'b0;
                                    state_reg        <= S_ADV_DIV;
                                end
                            end
                            ecstg_pkg::REQ_CLOCK:
                            begin
                                last_level_reg <= req.clock_level;
                                if (edge_hit)
                                begin
                                    if (arming_reg)
                                    begin
                                        arming_reg <= 1'b0;
                                        run_reg    <= 1'b1;
                                    end
                                    else
                                    begin
                                        hold_reg  <= 1'b0;
                                        n_rs_reg  <= n_rs;
                                        diff_reg  <= diff;
                                        dn_reg    <= dn;
                                        state_reg <= S_RS_MUL;
                                    end
                                end
                            end
                            ecstg_pkg::REQ_TEMPO:
                            begin
                                if (req.tempo_period != last_tempo_reg)
                                begin
                                    last_tempo_reg <= req.tempo_period;
                                    period_reg <= (req.tempo_period == 24'd0) ? 32'd1
                                                  : {8'b0, req.tempo_period};
                                    if (cfg.ext_sync_enable)
                                    begin
                                        if (run_reg)
                                        begin
                                            run_reg    <= 1'b0;
                                            arming_reg <= 1'b1;
                                        end
                                        else if (arming_reg)
                                        begin
                                            run_reg    <= 1'b1;
                                            arming_reg <= 1'b0;
                                        end
                                        frac_reg       <= '0;
                                        tick_total_reg <= '0;
                                        at_edge_reg    <= '0;
                                        since_reg      <= '0;
                                        hold_reg       <= 1'b0;
                                    end
                                end
                            end
                            ecstg_pkg::REQ_START:
                            begin
                                frac_reg       <= '0;
                                tick_total_reg <= '0;
                                at_edge_reg    <= '0;
                                since_reg      <= '0;
                                hold_reg       <= 1'b0;
                                run_reg        <= !cfg.ext_sync_enable;
                                arming_reg     <= cfg.ext_sync_enable;
                            end
                            ecstg_pkg::REQ_STOP:
                            begin
                                run_reg    <= 1'b0;
                                arming_reg <= 1'b0;
                                hold_reg   <= 1'b0;
                            end
                            default:
                            begin
                                n_reg <= 8'd0;
                            end
                        endcase
                    end
                end

                S_ADV_DIV:
                begin
                    if (div_st.done)
                    begin
                        frac_reg <= div_r;
                        if (hold_reg)
                        begin
                            since_reg <= since_sat;
                        end
                        else
                        begin
                            if (cfg.ext_sync_enable)
                            begin
                                since_reg <= since_sat;
                                if (over)
                                begin
                                    hold_reg <= 1'b1;
                                end
                            end
                            tick_total_reg <= tick_total_reg + adv_n[31:0];
                            n_reg          <= adv_n_sat;
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_RS_MUL:
                begin
                    // per correction numerator, registered before the divide
                    div_a_reg         <= prod;
                    div_b_reg         <= {22'b0, tpb_eff};
                    div_ctl_reg.start <= 1'b1;
                    div_ctl_reg.wide  <= 1'b1;
                    state_reg         <= S_RS_DIV;
                end

                S_RS_DIV:
                begin
                    if (div_st.done)
                    begin
                        frac_reg       <= '0;
                        at_edge_reg    <= edge_total;
                        tick_total_reg <= edge_total;
                        since_reg      <= '0;
                        period_reg     <= per_new;
                        n_reg          <= n_rs_reg;
                        state_reg      <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg <= 1'b1;
                        res_tick_reg  <= n_reg;
                        res_run_reg   <= run_reg;
                        res_hold_reg  <= hold_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign res.valid      = res_valid_reg;
    assign res.tick_count = res_tick_reg;
    assign res.running    = res_run_reg;
    assign res.holding    = res_hold_reg;

    // ---------------- assertions ----------------
    a_hold_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> run_reg)
        else $error("hold set while timeline not running");

    a_run_arm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && arming_reg))
        else $error("run and arming both set");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != 32'd0)
        else $error("beat period reached zero");

    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        (div_st.busy || div_st.done) |-> (state_reg == S_ADV_DIV || state_reg == S_RS_DIV))
        else $error("divider active outside a divide state");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!res_valid_reg || res.ready)) |=> res_valid_reg)
        else $error("finished item not moved to result register");

endmodule

`default_nettype wire
